// File: design/cld_pkg.sv
`timescale 1ns / 1ps

package cld_pkg;

  localparam int LINE_CAP    = 16;
  localparam int MAX_RESULTS = 48;
  localparam int NUM_REGS    = 5;

  localparam int IDX_W  = $clog2(LINE_CAP);
  localparam int LEN_W  = $clog2(LINE_CAP + 1);
  localparam int RES_W  = $clog2(MAX_RESULTS + 1);
  localparam int ADDR_W = $clog2(4 * NUM_REGS);

  // mode_flags bit positions
  localparam int F_CANON = 0;
  localparam int F_ECHO  = 1;
  localparam int F_ECHOE = 2;
  localparam int F_ISIG  = 3;
  localparam int F_ICRNL = 4;
  localparam int F_OPOST = 5;
  localparam int F_ONLCR = 6;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] LEAD_MASK = 8'hC0;
  localparam logic [7:0] CONT_PAT  = 8'h80;
  localparam logic [7:0] CTRL_MASK = 8'h1F;

  localparam logic [6:0] MODE_RST  = 7'h7F;
  localparam logic [7:0] INTR_RST  = 8'h03;
  localparam logic [7:0] ERASE_RST = 8'h7F;
  localparam logic [7:0] KILL_RST  = 8'h15;
  localparam logic [7:0] EOF_RST   = 8'h04;

  typedef enum logic [1:0] {
    OP_RX   = 2'd0,
    OP_TX   = 2'd1,
    OP_EOS  = 2'd2,
    OP_RSVD = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_EOF  = 2'd1,
    KIND_INTR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_INTR  = 3'd1,
    REG_ERASE = 3'd2,
    REG_KILL  = 3'd3,
    REG_EOF   = 3'd4
  } reg_idx_e;

  localparam logic DEST_TERM   = 1'b0;
  localparam logic DEST_READER = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ECHO1,
    ST_ECHO2,
    ST_INTR,
    ST_WALK,
    ST_ER1,
    ST_ER2,
    ST_ER3,
    ST_DELIV,
    ST_DONE
  } seq_state_e;

  typedef enum logic [1:0] {
    C_FINISH,
    C_DELIVER,
    C_INTR
  } cont_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] byte_value;
  } in_req_t;

  typedef struct packed {
    logic       destination;
    logic [7:0] data;
    kind_e      kind;
    logic       last;
  } out_rsp_t;

  typedef struct packed {
    logic [6:0] mode;
    logic [7:0] intr;
    logic [7:0] erase;
    logic [7:0] kill;
    logic [7:0] eof;
  } cfg_t;

  typedef struct packed {
    logic       push;
    logic       finish;
    logic       dest;
    logic [7:0] data;
    kind_e      kind;
  } emit_ctl_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             len_we;
    logic [LEN_W-1:0] len;
    logic [IDX_W-1:0] raddr;
  } lbuf_ctl_t;

  function automatic emit_ctl_t mk_push(logic dest, logic [7:0] data, kind_e kind);
    emit_ctl_t e;
    e        = '0;
    e.push   = 1'b1;
    e.dest   = dest;
    e.data   = data;
    e.kind   = kind;
    return e;
  endfunction

  function automatic logic is_ctrl(logic [7:0] b);
    return (b < CH_SPACE) || (b == CH_DEL);
  endfunction

  function automatic logic [7:0] ctrl_echo(logic [7:0] b);
    return (b == CH_DEL) ? CH_QMARK : (CH_AT + (b & CTRL_MASK));
  endfunction

endpackage

// File: design/canonical_line_discipline.sv
`timescale 1ns / 1ps

// Canonical terminal line discipline. Requests on the input channel are a
// received keystroke (edited into a line of up to LINE_CAP - 1 bytes plus
// newline, with echo), a byte to transmit (NL to CR NL when enabled) or end
// of stream (hands over the pending line). Results go out one per cycle,
// while the output is not stalled, through a registered output; last marks
// the final result of a request. One request is handled at a time by a small
// sequencer: a decode step, then a step per result (an echo step with echo
// off still takes one), a step to find the start of each erased character
// plus one per continuation byte skipped, and a closing step. Every step
// waits while a result is held on a stalled output, and the input stays
// stalled until the closing step is done.
// Registers sit at byte address 4*i: mode_flags, interrupt_char, erase_char,
// kill_char, eof_char.
module canonical_line_discipline (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  cld_pkg::in_req_t           in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output cld_pkg::out_rsp_t          out_rsp_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cld_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import cld_pkg::*;

  cfg_t             cfg_q;
  reg_idx_e         reg_idx;
  logic             wr_en;
  logic             step;
  emit_ctl_t        emit_ctl;
  lbuf_ctl_t        lbuf_ctl;
  logic [LEN_W-1:0] len;
  logic [7:0]       rdata;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode  <= MODE_RST;
      cfg_q.intr  <= INTR_RST;
      cfg_q.erase <= ERASE_RST;
      cfg_q.kill  <= KILL_RST;
      cfg_q.eof   <= EOF_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:  cfg_q.mode  <= pwdata[6:0];
        REG_INTR:  cfg_q.intr  <= pwdata[7:0];
        REG_ERASE: cfg_q.erase <= pwdata[7:0];
        REG_KILL:  cfg_q.kill  <= pwdata[7:0];
        REG_EOF:   cfg_q.eof   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:  prdata = {25'd0, cfg_q.mode};
      REG_INTR:  prdata = {24'd0, cfg_q.intr};
      REG_ERASE: prdata = {24'd0, cfg_q.erase};
      REG_KILL:  prdata = {24'd0, cfg_q.kill};
      REG_EOF:   prdata = {24'd0, cfg_q.eof};
      default:   prdata = '0;
    endcase
  end

  cld_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .cfg_i      (cfg_q),
    .step_i     (step),
    .emit_o     (emit_ctl),
    .lbuf_o     (lbuf_ctl),
    .len_i      (len),
    .rdata_i    (rdata)
  );

  cld_lbuf u_lbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (lbuf_ctl),
    .len_o   (len),
    .rdata_o (rdata)
  );

  cld_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (emit_ctl),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .step_o      (step)
  );

endmodule

// File: design/cld_lbuf.sv
`timescale 1ns / 1ps

module cld_lbuf (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cld_pkg::lbuf_ctl_t       ctl_i,
  output logic [cld_pkg::LEN_W-1:0] len_o,
  output logic [7:0]               rdata_o
);
  import cld_pkg::*;

  logic [7:0]       store_q [LINE_CAP];
  logic [LEN_W-1:0] len_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      store_q[ctl_i.waddr] <= ctl_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (ctl_i.len_we) begin
      len_q <= ctl_i.len;
    end
  end

  assign len_o   = len_q;
  assign rdata_o = store_q[ctl_i.raddr];

endmodule

// File: design/cld_emit.sv
`timescale 1ns / 1ps

module cld_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cld_pkg::emit_ctl_t ctl_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output cld_pkg::out_rsp_t  out_rsp_o,
  output logic               step_o
);
  import cld_pkg::*;

  logic             out_v_q, out_v_d;
  out_rsp_t         out_q, out_d;
  logic             pend_v_q, pend_v_d;
  out_rsp_t         pend_q, pend_d;
  logic [RES_W-1:0] cnt_q, cnt_d;
  logic             take;

  assign step_o = !out_v_q || !out_stall_i;
  assign take   = ctl_i.push && (cnt_q != RES_W'(MAX_RESULTS));

  // one result is held back so the final one can be tagged last
  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    cnt_d    = cnt_q;
    if (step_o) begin
      out_v_d = 1'b0;
    end
    if (take) begin
      if (pend_v_q) begin
        out_d      = pend_q;
        out_d.last = 1'b0;
        out_v_d    = 1'b1;
      end
      pend_d.destination = ctl_i.dest;
      pend_d.data        = ctl_i.data;
      pend_d.kind        = ctl_i.kind;
      pend_d.last        = 1'b0;
      pend_v_d           = 1'b1;
      cnt_d              = cnt_q + RES_W'(1);
    end
    if (ctl_i.finish) begin
      if (pend_v_q) begin
        out_d      = pend_q;
        out_d.last = 1'b1;
        out_v_d    = 1'b1;
      end
      pend_v_d = 1'b0;
      cnt_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      out_v_q  <= out_v_d;
      pend_v_q <= pend_v_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_valid_o = out_v_q;
  assign out_rsp_o   = out_q;

endmodule

// File: design/cld_seq.sv
`timescale 1ns / 1ps

module cld_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  cld_pkg::in_req_t          in_req_i,
  input  cld_pkg::cfg_t             cfg_i,
  input  logic                      step_i,
  output cld_pkg::emit_ctl_t        emit_o,
  output cld_pkg::lbuf_ctl_t        lbuf_o,
  input  logic [cld_pkg::LEN_W-1:0] len_i,
  input  logic [7:0]                rdata_i
);
  import cld_pkg::*;

  seq_state_e       state_q, state_d;
  op_e              op_q, op_d;
  logic [7:0]       b_q, b_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  cont_e            cont_q, cont_d;
  logic             kill_q, kill_d;

  logic       canon, echo, echoe, isig, icrnl, post;
  logic [7:0] cx;
  logic       room;
  seq_state_e cont_st;
  seq_state_e after_st;
  logic [IDX_W-1:0] len_m1;
  logic       is_cont;
  logic       deliv_end;

  assign canon = cfg_i.mode[F_CANON];
  assign echo  = cfg_i.mode[F_ECHO];
  assign echoe = cfg_i.mode[F_ECHOE];
  assign isig  = cfg_i.mode[F_ISIG];
  assign icrnl = cfg_i.mode[F_ICRNL];
  assign post  = cfg_i.mode[F_OPOST] && cfg_i.mode[F_ONLCR];

  assign cx      = (b_q == CH_CR && icrnl) ? CH_NL : b_q;
  assign room    = (cx == CH_NL) ? (len_i < LEN_W'(LINE_CAP))
                                 : (len_i < LEN_W'(LINE_CAP - 1));
  assign len_m1  = IDX_W'(len_i - LEN_W'(1));
  assign is_cont = (rdata_i & LEAD_MASK) == CONT_PAT;
  assign deliv_end = (LEN_W'(idx_q) + LEN_W'(1)) == len_i;

  always_comb begin
    unique case (cont_q)
      C_DELIVER: cont_st = ST_DELIV;
      C_INTR:    cont_st = ST_INTR;
      default:   cont_st = ST_DONE;
    endcase
  end

  assign after_st = (kill_q && len_i != '0) ? ST_WALK : ST_DONE;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    b_d          = b_q;
    idx_d        = idx_q;
    cont_d       = cont_q;
    kill_d       = kill_q;
    emit_o       = '0;
    lbuf_o       = '0;
    lbuf_o.raddr = idx_q;
    in_stall_o   = (state_q != ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_req_i.op;
          b_d     = in_req_i.byte_value;
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        if (step_i) begin
          unique case (op_q)
            OP_RX: begin
              if (!canon) begin
                emit_o  = mk_push(DEST_READER, b_q, KIND_DATA);
                state_d = ST_DONE;
              end else begin
                b_d = cx;
                priority if (isig && cx == cfg_i.intr) begin
                  lbuf_o.len_we = 1'b1;
                  lbuf_o.len    = '0;
                  cont_d        = C_INTR;
                  state_d       = ST_ECHO1;
                end else if (cx == cfg_i.erase || cx == CH_BS || cx == CH_DEL) begin
                  kill_d  = 1'b0;
                  idx_d   = len_m1;
                  state_d = (len_i == '0) ? ST_DONE : ST_WALK;
                end else if (cx == cfg_i.kill) begin
                  kill_d  = 1'b1;
                  idx_d   = len_m1;
                  state_d = (len_i == '0) ? ST_DONE : ST_WALK;
                end else if (cx == cfg_i.eof) begin
                  idx_d   = '0;
                  state_d = ST_DELIV;
                end else begin
                  if (room) begin
                    lbuf_o.we     = 1'b1;
                    lbuf_o.waddr  = IDX_W'(len_i);
                    lbuf_o.wdata  = cx;
                    lbuf_o.len_we = 1'b1;
                    lbuf_o.len    = len_i + LEN_W'(1);
                  end
                  cont_d  = (cx == CH_NL) ? C_DELIVER : C_FINISH;
                  state_d = ST_ECHO1;
                end
              end
            end
            OP_TX: begin
              if (b_q == CH_NL && post) begin
                emit_o  = mk_push(DEST_TERM, CH_CR, KIND_DATA);
                cont_d  = C_FINISH;
                state_d = ST_ECHO2;
              end else begin
                emit_o  = mk_push(DEST_TERM, b_q, KIND_DATA);
                state_d = ST_DONE;
              end
            end
            OP_EOS: begin
              idx_d   = '0;
              state_d = ST_DELIV;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      ST_ECHO1: begin
        if (step_i) begin
          idx_d = '0;
          priority if (!echo) begin
            state_d = cont_st;
          end else if (b_q == CH_NL || b_q == CH_CR) begin
            if (post) begin
              emit_o  = mk_push(DEST_TERM, CH_CR, KIND_DATA);
              state_d = ST_ECHO2;
            end else begin
              emit_o  = mk_push(DEST_TERM, CH_NL, KIND_DATA);
              state_d = cont_st;
            end
          end else if (is_ctrl(b_q)) begin
            emit_o  = mk_push(DEST_TERM, CH_CARET, KIND_DATA);
            state_d = ST_ECHO2;
          end else begin
            emit_o  = mk_push(DEST_TERM, b_q, KIND_DATA);
            state_d = cont_st;
          end
        end
      end

      ST_ECHO2: begin
        if (step_i) begin
          idx_d   = '0;
          emit_o  = mk_push(DEST_TERM,
                            (b_q == CH_NL || b_q == CH_CR) ? CH_NL : ctrl_echo(b_q),
                            KIND_DATA);
          state_d = cont_st;
        end
      end

      ST_INTR: begin
        if (step_i) begin
          emit_o  = mk_push(DEST_READER, 8'h00, KIND_INTR);
          state_d = ST_DONE;
        end
      end

      // walk back over UTF-8 continuation bytes, never past index 0
      ST_WALK: begin
        if (step_i) begin
          if (idx_q != '0 && is_cont) begin
            idx_d = idx_q - IDX_W'(1);
          end else begin
            lbuf_o.len_we = 1'b1;
            lbuf_o.len    = LEN_W'(idx_q);
            state_d       = ST_ER1;
          end
        end
      end

      ST_ER1: begin
        if (step_i) begin
          idx_d = len_m1;
          priority if (echoe) begin
            emit_o  = mk_push(DEST_TERM, CH_BS, KIND_DATA);
            state_d = ST_ER2;
          end else if (echo) begin
            emit_o  = mk_push(DEST_TERM, CH_BS, KIND_DATA);
            state_d = after_st;
          end else begin
            state_d = after_st;
          end
        end
      end

      ST_ER2: begin
        if (step_i) begin
          emit_o  = mk_push(DEST_TERM, CH_SPACE, KIND_DATA);
          state_d = ST_ER3;
        end
      end

      ST_ER3: begin
        if (step_i) begin
          idx_d   = len_m1;
          emit_o  = mk_push(DEST_TERM, CH_BS, KIND_DATA);
          state_d = after_st;
        end
      end

      ST_DELIV: begin
        if (step_i) begin
          if (len_i == '0) begin
            emit_o  = mk_push(DEST_READER, 8'h00, KIND_EOF);
            state_d = ST_DONE;
          end else begin
            emit_o = mk_push(DEST_READER, rdata_i, KIND_DATA);
            if (deliv_end) begin
              lbuf_o.len_we = 1'b1;
              lbuf_o.len    = '0;
              state_d       = ST_DONE;
            end else begin
              idx_d = idx_q + IDX_W'(1);
            end
          end
        end
      end

      ST_DONE: begin
        if (step_i) begin
          emit_o.finish = 1'b1;
          state_d       = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_RX;
      b_q     <= '0;
      idx_q   <= '0;
      cont_q  <= C_FINISH;
      kill_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      b_q     <= b_d;
      idx_q   <= idx_d;
      cont_q  <= cont_d;
      kill_q  <= kill_d;
    end
  end

endmodule

// File: design/cld_checker.sv
`timescale 1ns / 1ps

module cld_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input cld_pkg::out_rsp_t out_rsp_o
);
  import cld_pkg::*;

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while busy");

  a_marker_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.kind != KIND_DATA |->
      out_rsp_o.destination == DEST_READER && out_rsp_o.data == 8'h00)
    else $error("malformed marker result");

  a_intr_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.kind == KIND_INTR |-> out_rsp_o.last)
    else $error("interrupt report not final");

  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.kind == KIND_EOF |-> out_rsp_o.last)
    else $error("end of file report not final");

endmodule

bind canonical_line_discipline cld_checker u_cld_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import cld_pkg::*;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_req_t             in_req_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b1;
  out_rsp_t            out_rsp_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ADDR_W-1:0]   paddr       = '0;
  logic [31:0]         pwdata      = '0;
  logic [31:0]         prdata;
  logic                pready;

  always #1 clk_i = ~clk_i;

  canonical_line_discipline dut (.*);

  // line editor state as seen from outside
  logic [6:0] mode_r  = MODE_RST;
  logic [7:0] intr_r  = INTR_RST;
  logic [7:0] erase_r = ERASE_RST;
  logic [7:0] kill_r  = KILL_RST;
  logic [7:0] eof_r   = EOF_RST;
  logic [7:0] line_buf [LINE_CAP];
  int         line_len = 0;

  out_rsp_t   step_rsp[$];
  out_rsp_t   pending_rsp[$];

  int n_items, n_ignored, n_settings, n_checked, n_reader, n_eof, n_intr;
  int mismatches;
  bit tx_gapless, rx_quiet;

  function automatic void push_rsp(logic dest, logic [7:0] d, kind_e k);
    out_rsp_t r;
    if (step_rsp.size() >= MAX_RESULTS) return;
    r.destination = dest;
    r.data        = d;
    r.kind        = k;
    r.last        = 1'b0;
    step_rsp.push_back(r);
  endfunction

  function automatic void term_out(logic [7:0] b);
    if (b == CH_NL && mode_r[F_OPOST] && mode_r[F_ONLCR]) begin
      push_rsp(DEST_TERM, CH_CR, KIND_DATA);
      push_rsp(DEST_TERM, CH_NL, KIND_DATA);
    end else begin
      push_rsp(DEST_TERM, b, KIND_DATA);
    end
  endfunction

  function automatic void echo_key(logic [7:0] b);
    logic [7:0] shown;
    if (!mode_r[F_ECHO]) return;
    if (b == CH_NL || b == CH_CR) begin
      term_out(CH_NL);
    end else if (b < CH_SPACE || b == CH_DEL) begin
      shown = (b == CH_DEL) ? CH_QMARK : 8'(CH_AT + (b & CTRL_MASK));
      term_out(CH_CARET);
      term_out(shown);
    end else begin
      term_out(b);
    end
  endfunction

  function automatic void rub_out_echo();
    if (mode_r[F_ECHOE]) begin
      push_rsp(DEST_TERM, CH_BS, KIND_DATA);
      push_rsp(DEST_TERM, CH_SPACE, KIND_DATA);
      push_rsp(DEST_TERM, CH_BS, KIND_DATA);
    end else if (mode_r[F_ECHO]) begin
      push_rsp(DEST_TERM, CH_BS, KIND_DATA);
    end
  endfunction

  // drop one codepoint: skip UTF-8 continuation bytes, stop at the line start
  function automatic void erase_back();
    int i;
    if (line_len == 0) return;
    i = line_len - 1;
    while (i > 0 && (line_buf[i] & LEAD_MASK) == CONT_PAT) i--;
    line_len = i;
    rub_out_echo();
  endfunction

  function automatic void hand_over_line();
    if (line_len == 0) begin
      push_rsp(DEST_READER, 8'h00, KIND_EOF);
      return;
    end
    for (int i = 0; i < line_len; i++) push_rsp(DEST_READER, line_buf[i], KIND_DATA);
    line_len = 0;
  endfunction

  function automatic void edit_key(logic [7:0] key);
    logic [7:0] c;
    c = key;
    if (!mode_r[F_CANON]) begin
      push_rsp(DEST_READER, c, KIND_DATA);
      return;
    end
    if (c == CH_CR && mode_r[F_ICRNL]) c = CH_NL;
    if (mode_r[F_ISIG] && c == intr_r) begin
      echo_key(c);
      line_len = 0;
      push_rsp(DEST_READER, 8'h00, KIND_INTR);
      return;
    end
    if (c == erase_r || c == CH_BS || c == CH_DEL) begin
      erase_back();
      return;
    end
    if (c == kill_r) begin
      while (line_len > 0) erase_back();
      return;
    end
    if (c == eof_r) begin
      hand_over_line();
      return;
    end
    echo_key(c);
    if (c == CH_NL) begin
      if (line_len < LINE_CAP) begin
        line_buf[line_len] = c;
        line_len++;
      end
      hand_over_line();
      return;
    end
    if (line_len < LINE_CAP - 1) begin
      line_buf[line_len] = c;
      line_len++;
    end
  endfunction

  function automatic void predict_request(in_req_t req);
    out_rsp_t t;
    step_rsp.delete();
    case (req.op)
      OP_RX:   edit_key(req.byte_value);
      OP_TX:   term_out(req.byte_value);
      OP_EOS:  hand_over_line();
      default: ;
    endcase
    if (step_rsp.size() > 0) begin
      t = step_rsp.pop_back();
      t.last = 1'b1;
      step_rsp.push_back(t);
    end
    foreach (step_rsp[i]) pending_rsp.push_back(step_rsp[i]);
  endfunction

  task automatic send_req(op_e op, logic [7:0] b);
    int      gap;
    bit      taken;
    in_req_t req;
    req.op         = op;
    req.byte_value = b;
    if ($urandom_range(0, 15) == 0) tx_gapless = !tx_gapless;
    gap = tx_gapless ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    predict_request(req);
    if (op == OP_RSVD) n_ignored++;
    else n_items++;
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  // requests that give no result may still be in flight
  task automatic settle();
    hold_until_drained();
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * idx);
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODE:  mode_r  = value[6:0];
      REG_INTR:  intr_r  = value;
      REG_ERASE: erase_r = value;
      REG_KILL:  kill_r  = value;
      REG_EOF:   eof_r   = value;
      default:   ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [6:0] mode, logic [7:0] intr, logic [7:0] erase,
                            logic [7:0] kill, logic [7:0] eofc);
    settle();
    write_reg(REG_MODE, {1'b0, mode});
    write_reg(REG_INTR, intr);
    write_reg(REG_ERASE, erase);
    write_reg(REG_KILL, kill);
    write_reg(REG_EOF, eofc);
    n_settings++;
  endtask

  task automatic check_rsp(out_rsp_t got);
    out_rsp_t want;
    if (pending_rsp.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: dest=%0d data=%02h kind=%0d last=%0d",
                 got.destination, got.data, got.kind, got.last);
      return;
    end
    want = pending_rsp.pop_front();
    n_checked++;
    if (want.destination == DEST_READER) n_reader++;
    if (want.kind == KIND_EOF) n_eof++;
    if (want.kind == KIND_INTR) n_intr++;
    if (got.destination !== want.destination || got.data !== want.data ||
        got.kind !== want.kind || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected dest=%0d data=%02h kind=%0d last=%0d, got dest=%0d data=%02h kind=%0d last=%0d",
                 want.destination, want.data, want.kind, want.last,
                 got.destination, got.data, got.kind, got.last);
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_rsp(out_rsp_o);
  end

  initial begin
    int n;
    bit got;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 24) == 0) rx_quiet = !rx_quiet;
      n = rx_quiet ? 0 : $urandom_range(0, 17);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        got = out_valid_o;
        @(posedge clk_i);
      end while (!got);
    end
  end

  function automatic logic [7:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'($urandom_range(8'h20, 8'h7E));
    if (r < 65) return 8'($urandom_range(8'hC0, 8'hF7));
    if (r < 78) return 8'($urandom_range(8'h80, 8'hBF));
    if (r < 81) return CH_BS;
    if (r < 83) return CH_DEL;
    if (r < 86) return erase_r;
    if (r < 92) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 8'h1F));
  endfunction

  function automatic logic [7:0] pick_char(logic [7:0] dflt);
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return dflt;
    if (r == 5) return 8'h00;
    if (r == 6) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_line();
    int len;
    int r;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 8);
    repeat (len) send_req(OP_RX, pick_key());
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3: send_req(OP_RX, CH_NL);
      4:          send_req(OP_RX, CH_CR);
      5:          send_req(OP_RX, eof_r);
      6:          send_req(OP_RX, kill_r);
      7:          send_req(OP_RX, intr_r);
      8:          send_req(OP_EOS, 8'($urandom_range(0, 255)));
      default:    ;
    endcase
  endtask

  task automatic test_editing();
    send_req(OP_RX, CH_BS);        // erase on empty line
    send_req(OP_RX, 8'h80);        // lone continuation bytes
    send_req(OP_RX, 8'h80);
    send_req(OP_RX, CH_DEL);
    send_req(OP_RX, 8'h61);
    send_req(OP_RX, 8'hC3);        // two-byte codepoint
    send_req(OP_RX, 8'hA9);
    send_req(OP_RX, CH_DEL);
    send_req(OP_RX, 8'h01);        // caret echo
    send_req(OP_RX, KILL_RST);
    send_req(OP_RX, EOF_RST);      // eof on empty line
    send_req(OP_RX, 8'h78);
    send_req(OP_RX, EOF_RST);      // eof delivers pending line
    send_req(OP_RX, 8'h79);
    send_req(OP_RX, INTR_RST);
    send_req(OP_RX, CH_CR);
    send_req(OP_TX, CH_NL);
    send_req(OP_TX, 8'h00);
    send_req(OP_EOS, 8'hFF);
    send_req(OP_RSVD, 8'hFF);
  endtask

  task automatic test_full_line();
    for (int i = 0; i < LINE_CAP; i++) send_req(OP_RX, 8'(8'h41 + i));
    hold_until_drained();
    send_req(OP_RX, KILL_RST);     // longest echo burst
  endtask

  task automatic test_modes();
    set_config(7'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    send_req(OP_RX, 8'h00);
    send_req(OP_RX, 8'hFF);
    send_req(OP_RX, CH_CR);
    send_req(OP_TX, CH_NL);
    send_req(OP_EOS, 8'h00);
    // canonical, echo and output post only; erase and kill share a byte
    set_config(7'h23, 8'hFF, 8'h00, 8'h00, CH_CR);
    send_req(OP_RX, CH_CR);
    send_req(OP_RX, 8'h71);
    send_req(OP_RX, 8'h00);
    send_req(OP_RX, 8'hFF);
    send_req(OP_RX, CH_NL);
  endtask

  task automatic test_random_phase(int count);
    int target;
    int r;
    logic [6:0] mode;
    mode = ($urandom_range(0, 99) < 15) ? 7'($urandom_range(0, 127))
                                        : 7'($urandom_range(0, 127) | 1);
    set_config(mode, pick_char(INTR_RST), pick_char(ERASE_RST),
               pick_char(KILL_RST), pick_char(EOF_RST));
    tx_gapless = $urandom_range(0, 1);
    target = n_items + count;
    while (n_items < target) begin
      r = $urandom_range(0, 99);
      if (r < 60) send_line();
      else if (r < 72) send_req(OP_TX, $urandom_range(0, 1) ? CH_NL : 8'($urandom_range(0, 255)));
      else if (r < 80) send_req(OP_EOS, 8'($urandom_range(0, 255)));
      else if (r < 84) send_req(OP_RSVD, 8'($urandom_range(0, 255)));
      else if (r < 96) send_req(OP_RX, 8'($urandom_range(0, 255)));
      else hold_until_drained();
    end
  endtask

  initial begin
    #3000000;
    $display("[canonical_line_discipline] ERROR");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_editing();
    test_full_line();
    test_modes();
    for (int p = 0; p < 8; p++) test_random_phase(40);
    settle();
    mismatches += pending_rsp.size();
    $display("sent %0d requests (plus %0d unused op codes) under %0d register settings",
             n_items, n_ignored, n_settings + 1);
    $display("checked %0d results: %0d to the reader, %0d end-of-file, %0d interrupts",
             n_checked, n_reader, n_eof, n_intr);
    if (mismatches == 0) begin
      $display("[canonical_line_discipline] OK");
    end else begin
      $display("[canonical_line_discipline] ERROR");
    end
    $finish;
  end

endmodule
